// File: design/ccr_pkg.sv
// Shared constants and the linearisation table function of the contrast ratio block.
`timescale 1ns / 1ps

package ccr_pkg;

   localparam int unsigned CODE_W      = 8;
   localparam int unsigned ROM_DEPTH   = 256;
   localparam int unsigned LIN_MAX_W   = 25;
   localparam int unsigned WEIGHT_W    = 13;
   localparam int unsigned CHANNELS    = 6;
   localparam int unsigned WORK_BITS   = 30;
   localparam int unsigned OFFSET_UNITS = 500;

   typedef logic [WEIGHT_W-1:0] weight_type;

   localparam weight_type WEIGHTS [3] = '{13'd2126, 13'd7152, 13'd722};

   function automatic longint unsigned qmul(input longint unsigned a,
                                           input longint unsigned b);
      return (a * b) >> WORK_BITS;
   endfunction

   function automatic longint unsigned qpow5(input longint unsigned t);
      longint unsigned p;
      p = qmul(t, t);
      p = qmul(p, t);
      p = qmul(p, t);
      return qmul(p, t);
   endfunction

   function automatic logic [LIN_MAX_W-1:0] lin_entry(input int unsigned code,
                                                      input int unsigned frac_bits);
      longint unsigned v;
      longint unsigned n;
      longint unsigned x;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned y;
      longint unsigned res;
      int unsigned     sh;
      v = longint'(code);
      if (v * 100000 <= 1001640) begin
         res = (((v * 100) << frac_bits) + 164730) / 329460;
      end else begin
         n  = 1000 * v + 14025;
         x  = ((n << WORK_BITS) + 134512) / 269025;
         lo = 0;
         hi = longint'(1) << WORK_BITS;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (qpow5(mid) <= x) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         y   = qmul(qmul(x, x), qmul(lo, lo));
         sh  = WORK_BITS - frac_bits;
         res = (y + (longint'(1) << (sh - 1))) >> sh;
      end
      return LIN_MAX_W'(res);
   endfunction

endpackage

// File: design/ccr_luma.sv
// Linearisation, weighting, luminance sums and ordering of the two colours.
`timescale 1ns / 1ps

module ccr_luma #(
   parameter int unsigned LUMA_FRAC_BITS = 16,
   parameter int unsigned SUM_W          = LUMA_FRAC_BITS + 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ccr_pkg::CODE_W-1:0]    fg_red,
   input  logic [ccr_pkg::CODE_W-1:0]    fg_green,
   input  logic [ccr_pkg::CODE_W-1:0]    fg_blue,
   input  logic [ccr_pkg::CODE_W-1:0]    bg_red,
   input  logic [ccr_pkg::CODE_W-1:0]    bg_green,
   input  logic [ccr_pkg::CODE_W-1:0]    bg_blue,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [SUM_W-1:0]              out_num,
   output logic [SUM_W-1:0]              out_den
);

   localparam int unsigned EW     = LUMA_FRAC_BITS + 1;
   localparam int unsigned PW     = EW + ccr_pkg::WEIGHT_W;
   localparam int unsigned STAGES = 5;
   localparam int unsigned CH     = ccr_pkg::CHANNELS;
   localparam logic [SUM_W-1:0] OFFSET = SUM_W'(ccr_pkg::OFFSET_UNITS) << LUMA_FRAC_BITS;

   logic [EW-1:0] lin_rom [ccr_pkg::ROM_DEPTH];

   for (genvar i = 0; i < ccr_pkg::ROM_DEPTH; i++) begin : g_rom
      localparam logic [ccr_pkg::LIN_MAX_W-1:0] ENTRY = ccr_pkg::lin_entry(i, LUMA_FRAC_BITS);
      assign lin_rom[i] = ENTRY[EW-1:0];
   end

   logic [STAGES-1:0]          valid_ff;
   logic [STAGES-1:0]          stage_en;
   logic [ccr_pkg::CODE_W-1:0] code_in [CH];
   logic [ccr_pkg::CODE_W-1:0] code_ff [CH];
   logic [EW-1:0]              lin_ff  [CH];
   logic [PW-1:0]              prod_ff [CH];
   logic [SUM_W-1:0]           sum_fg_ff;
   logic [SUM_W-1:0]           sum_bg_ff;
   logic [SUM_W-1:0]           num_ff;
   logic [SUM_W-1:0]           den_ff;

   assign code_in[0] = fg_red;
   assign code_in[1] = fg_green;
   assign code_in[2] = fg_blue;
   assign code_in[3] = bg_red;
   assign code_in[4] = bg_green;
   assign code_in[5] = bg_blue;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_num   = num_ff;
   assign out_den   = den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   for (genvar c = 0; c < CH; c++) begin : g_chan
      always_ff @(posedge clock) begin
         if (stage_en[0]) begin
            code_ff[c] <= code_in[c];
         end
         if (stage_en[1]) begin
            lin_ff[c] <= lin_rom[code_ff[c]];
         end
         if (stage_en[2]) begin
            prod_ff[c] <= PW'(lin_ff[c]) * PW'(ccr_pkg::WEIGHTS[c % 3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sum_fg_ff <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
         sum_bg_ff <= SUM_W'(prod_ff[3]) + SUM_W'(prod_ff[4]) + SUM_W'(prod_ff[5]);
      end
      if (stage_en[4]) begin
         if (sum_fg_ff >= sum_bg_ff) begin
            num_ff <= sum_fg_ff + OFFSET;
            den_ff <= sum_bg_ff + OFFSET;
         end else begin
            num_ff <= sum_bg_ff + OFFSET;
            den_ff <= sum_fg_ff + OFFSET;
         end
      end
   end

endmodule

// File: design/ccr_divider.sv
// Pipelined restoring divider giving the rounded ratio, one quotient bit per stage.
`timescale 1ns / 1ps

module ccr_divider #(
   parameter int unsigned RATIO_FRAC_BITS = 10,
   parameter int unsigned SUM_W           = 30,
   parameter int unsigned QW              = RATIO_FRAC_BITS + 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [SUM_W-1:0] num,
   input  logic [SUM_W-1:0] den,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [QW-1:0]    quotient
);

   localparam int unsigned DW = SUM_W + QW;

   logic [QW:0]      valid_ff;
   logic [QW:0]      stage_en;
   logic [DW-1:0]    rem_ff [QW];
   logic [SUM_W-1:0] den_ff [QW];
   logic [QW-1:0]    q_ff   [QW+1];

   always_comb begin
      stage_en[QW] = !valid_ff[QW] || out_ready;
      for (int i = QW - 1; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[QW];
   assign quotient  = q_ff[QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i <= QW; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0] <= (DW'(num) << RATIO_FRAC_BITS) + DW'(den >> 1);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int unsigned BIT = QW - 1 - j;
      logic [DW-1:0] trial;
      logic          fits;
      assign trial = DW'(den_ff[j]) << BIT;
      assign fits  = rem_ff[j] >= trial;

      always_ff @(posedge clock) begin
         if (stage_en[j+1]) begin
            q_ff[j+1] <= fits ? (q_ff[j] | (QW'(1) << BIT)) : q_ff[j];
         end
      end

      if (j < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[j+1]) begin
               rem_ff[j+1] <= fits ? (rem_ff[j] - trial) : rem_ff[j];
               den_ff[j+1] <= den_ff[j];
            end
         end
      end
   end

endmodule

// File: design/color_contrast_ratio.sv
// Top level of the contrast ratio block: luminance front end and ratio divider.
// Pipeline: five luminance stages, one divider set-up stage and one stage per quotient bit.
// Throughput: one word per cycle while rsp_ready keeps up; every stage moves on when its
// successor has room, so a stall at rsp_ready holds each full stage behind it.
// Reset clears all stage valid bits; no word is in flight afterwards.
`timescale 1ns / 1ps

module color_contrast_ratio #(
   parameter int unsigned RATIO_FRAC_BITS = 10,
   parameter int unsigned LUMA_FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ccr_pkg::CODE_W-1:0]   req_fg_red,
   input  logic [ccr_pkg::CODE_W-1:0]   req_fg_green,
   input  logic [ccr_pkg::CODE_W-1:0]   req_fg_blue,
   input  logic [ccr_pkg::CODE_W-1:0]   req_bg_red,
   input  logic [ccr_pkg::CODE_W-1:0]   req_bg_green,
   input  logic [ccr_pkg::CODE_W-1:0]   req_bg_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [RATIO_FRAC_BITS+4:0]   rsp_contrast_ratio
);

   localparam int unsigned SUM_W = LUMA_FRAC_BITS + 14;
   localparam int unsigned QW    = RATIO_FRAC_BITS + 5;

   logic             mid_valid;
   logic             mid_ready;
   logic [SUM_W-1:0] mid_num;
   logic [SUM_W-1:0] mid_den;

   ccr_luma #(
      .LUMA_FRAC_BITS (LUMA_FRAC_BITS),
      .SUM_W          (SUM_W)
   ) u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .fg_red    (req_fg_red),
      .fg_green  (req_fg_green),
      .fg_blue   (req_fg_blue),
      .bg_red    (req_bg_red),
      .bg_green  (req_bg_green),
      .bg_blue   (req_bg_blue),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_num   (mid_num),
      .out_den   (mid_den)
   );

   ccr_divider #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
      .SUM_W           (SUM_W),
      .QW              (QW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .num       (mid_num),
      .den       (mid_den),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .quotient  (rsp_contrast_ratio)
   );

endmodule
